>>> hw/rtl/ffba_pkg.sv
// Shared types, constants and helpers of the first-fit block allocator.
// Used by ffba_seq and first_fit_block_allocator; depends on nothing.
`default_nettype none

package ffba_pkg;

   localparam int HEAP_BYTES  = 4096;
   localparam int STORE_DEPTH = HEAP_BYTES / 8;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int HDR_W       = 14;
   localparam int OFF_W       = 12;
   localparam int POS_W       = 15;

   localparam logic [POS_W-1:0] FIRST_HDR    = POS_W'(4);
   localparam logic [POS_W-1:0] HEAP_LIMIT   = POS_W'(HEAP_BYTES) & ~POS_W'(7);
   localparam logic [POS_W-1:0] STORE_END    = POS_W'(STORE_DEPTH * 8);
   localparam logic [HDR_W-1:0] SENTINEL_VAL = HDR_W'(1);
   localparam logic [OFF_W-1:0] HEAP_REQ_RST = OFF_W'(4084);

   typedef enum logic [1:0] {
      CMD_FORMAT   = 2'd0,
      CMD_ALLOC    = 2'd1,
      CMD_FREE     = 2'd2,
      CMD_COALESCE = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type          cmd;
      logic [OFF_W-1:0] request_bytes;
      logic [OFF_W-1:0] block_offset;
      logic [OFF_W-1:0] heap_request;
   } job_type;

   typedef struct packed {
      logic             ok;
      logic [OFF_W-1:0] result_offset;
   } result_type;

   function automatic logic [POS_W-1:0] round8(input logic [POS_W-1:0] v);
      round8 = (v + POS_W'(7)) & ~POS_W'(7);
   endfunction

   function automatic logic valid_pos(input logic [POS_W-1:0] p);
      valid_pos = (p[2:0] == 3'd4) && (p < STORE_END);
   endfunction

   function automatic logic [ADDR_W-1:0] row_of(input logic [POS_W-1:0] p);
      row_of = p[ADDR_W+2:3];
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ffba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the block headers; no dependencies.
`default_nettype none

module ffba_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> hw/rtl/ffba_seq.sv
// Command sequencer and shared walk datapath of the allocator.
// Depends on ffba_pkg and ffba_ram (the header store).
`default_nettype none

module ffba_seq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                job_valid,
   input  wire ffba_pkg::job_type   job,
   output logic                     job_ready,
   output logic                     done_valid,
   output ffba_pkg::result_type     result,
   input  wire logic                done_ready
);

   typedef enum logic [3:0] {
      S_IDLE, S_FMT, S_ACHK, S_AEVAL, S_AWR, S_CINIT, S_CFIRST,
      S_CCHK, S_CEVAL, S_FRD, S_FWR, S_DONE
   } state_type;

   state_type                        state_ff, state_in;
   logic [ffba_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic [ffba_pkg::POS_W-1:0]       lag_ff, lag_in;
   logic [ffba_pkg::POS_W-1:0]       need_ff, need_in;
   logic [ffba_pkg::HDR_W-1:0]       hg_ff, hg_in;
   logic [ffba_pkg::OFF_W-1:0]       sent_ff, sent_in;
   logic                             fmt_ff, fmt_in;
   logic                             ok_ff, ok_in;
   logic [ffba_pkg::OFF_W-1:0]       res_ff, res_in;

   logic                             wr_en;
   logic [ffba_pkg::POS_W-1:0]       wr_pos;
   logic [ffba_pkg::HDR_W-1:0]       wr_data;
   logic [ffba_pkg::POS_W-1:0]       rd_pos;
   logic [ffba_pkg::HDR_W-1:0]       rd_data;

   logic [ffba_pkg::POS_W-1:0]       hdr;
   logic [ffba_pkg::POS_W-1:0]       sz;
   logic [ffba_pkg::POS_W-1:0]       sent_ext;
   logic [ffba_pkg::POS_W-1:0]       total;
   logic                             in_heap;

   ffba_ram #(
      .WIDTH (ffba_pkg::HDR_W),
      .DEPTH (ffba_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en && ffba_pkg::valid_pos(wr_pos)),
      .wr_addr (ffba_pkg::row_of(wr_pos)),
      .wr_data (wr_data),
      .rd_addr (ffba_pkg::row_of(rd_pos)),
      .rd_data (rd_data)
   );

   assign hdr        = ffba_pkg::POS_W'(rd_data);
   assign sz         = hdr & ~ffba_pkg::POS_W'(1);
   assign sent_ext   = ffba_pkg::POS_W'(sent_ff);
   assign in_heap    = (pos_ff < sent_ext) && ffba_pkg::valid_pos(pos_ff);
   assign job_ready  = (state_ff == S_IDLE);
   assign done_valid = (state_ff == S_DONE);
   assign result     = '{ok: ok_ff, result_offset: res_ff};

   always_comb begin
      total = ffba_pkg::round8(ffba_pkg::POS_W'(job.heap_request) + ffba_pkg::POS_W'(12));
      if (total > ffba_pkg::HEAP_LIMIT) begin
         total = ffba_pkg::HEAP_LIMIT;
      end
   end

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      lag_in   = lag_ff;
      need_in  = need_ff;
      hg_in    = hg_ff;
      sent_in  = sent_ff;
      fmt_in   = fmt_ff;
      ok_in    = ok_ff;
      res_in   = res_ff;
      wr_en    = 1'b0;
      wr_pos   = pos_ff;
      wr_data  = '0;
      rd_pos   = pos_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               ok_in  = 1'b0;
               res_in = '0;
               if (job.cmd == ffba_pkg::CMD_FORMAT) begin
                  wr_en    = 1'b1;
                  wr_pos   = ffba_pkg::FIRST_HDR;
                  wr_data  = ffba_pkg::HDR_W'(total - ffba_pkg::POS_W'(8));
                  sent_in  = ffba_pkg::OFF_W'(total - ffba_pkg::POS_W'(4));
                  state_in = S_FMT;
               end else if (!fmt_ff) begin
                  state_in = S_DONE;
               end else begin
                  unique case (job.cmd)
                     ffba_pkg::CMD_ALLOC: begin
                        need_in  = ffba_pkg::round8(ffba_pkg::POS_W'(job.request_bytes)
                                                    + ffba_pkg::POS_W'(4));
                        pos_in   = ffba_pkg::FIRST_HDR;
                        state_in = S_ACHK;
                     end
                     ffba_pkg::CMD_FREE: begin
                        pos_in = ffba_pkg::POS_W'(job.block_offset);
                        if (ffba_pkg::valid_pos(ffba_pkg::POS_W'(job.block_offset))
                            && (job.block_offset < sent_ff)) begin
                           state_in = S_FRD;
                        end else begin
                           state_in = S_DONE;
                        end
                     end
                     default: begin
                        state_in = S_CINIT;
                     end
                  endcase
               end
            end
         end
         S_FMT: begin
            wr_en    = 1'b1;
            wr_pos   = sent_ext;
            wr_data  = ffba_pkg::SENTINEL_VAL;
            fmt_in   = 1'b1;
            ok_in    = 1'b1;
            state_in = S_DONE;
         end
         S_ACHK: begin
            rd_pos   = pos_ff;
            state_in = in_heap ? S_AEVAL : S_DONE;
         end
         S_AEVAL: begin
            if (sz == '0) begin
               state_in = S_DONE;
            end else if (!hdr[0] && (sz >= need_ff)) begin
               wr_en    = (sz != need_ff);
               wr_pos   = pos_ff + need_ff;
               wr_data  = ffba_pkg::HDR_W'(sz - need_ff);
               state_in = S_AWR;
            end else begin
               pos_in   = pos_ff + sz;
               state_in = S_ACHK;
            end
         end
         S_AWR: begin
            wr_en    = 1'b1;
            wr_pos   = pos_ff;
            wr_data  = ffba_pkg::HDR_W'(need_ff | ffba_pkg::POS_W'(1));
            ok_in    = 1'b1;
            res_in   = ffba_pkg::OFF_W'(pos_ff);
            state_in = S_DONE;
         end
         S_CINIT: begin
            rd_pos   = ffba_pkg::FIRST_HDR;
            state_in = S_CFIRST;
         end
         S_CFIRST: begin
            hg_in    = rd_data;
            lag_in   = ffba_pkg::FIRST_HDR;
            pos_in   = ffba_pkg::FIRST_HDR + sz;
            state_in = S_CCHK;
         end
         S_CCHK: begin
            rd_pos = pos_ff;
            if (in_heap) begin
               state_in = S_CEVAL;
            end else begin
               ok_in    = 1'b1;
               state_in = S_DONE;
            end
         end
         S_CEVAL: begin
            if (sz == '0) begin
               ok_in    = 1'b1;
               state_in = S_DONE;
            end else begin
               if (!hdr[0] && !hg_ff[0]) begin
                  wr_en   = 1'b1;
                  wr_pos  = lag_ff;
                  wr_data = ffba_pkg::HDR_W'(ffba_pkg::POS_W'(hg_ff) + sz);
                  hg_in   = ffba_pkg::HDR_W'(ffba_pkg::POS_W'(hg_ff) + sz);
               end else begin
                  lag_in = pos_ff;
                  hg_in  = rd_data;
               end
               pos_in   = pos_ff + sz;
               state_in = S_CCHK;
            end
         end
         S_FRD: begin
            rd_pos   = pos_ff;
            state_in = S_FWR;
         end
         S_FWR: begin
            wr_en    = 1'b1;
            wr_pos   = pos_ff;
            wr_data  = rd_data & ~ffba_pkg::HDR_W'(1);
            ok_in    = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (done_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sent_ff  <= '0;
         fmt_ff   <= 1'b0;
         ok_ff    <= 1'b0;
         res_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sent_ff  <= sent_in;
         fmt_ff   <= fmt_in;
         ok_ff    <= ok_in;
         res_ff   <= res_in;
      end
      pos_ff  <= pos_in;
      lag_ff  <= lag_in;
      need_ff <= need_in;
      hg_ff   <= hg_in;
   end

endmodule

`default_nettype wire

>>> hw/rtl/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: stream ports, heap size register
// and result register around ffba_seq. Depends on ffba_pkg and ffba_seq.
//
//  channel  dir  handshake             payload
//  req_     in   req_tvalid/tready     tuser command, tdata request_bytes/block_offset
//  rsp_     out  rsp_tvalid/tready     tuser ok, tdata result_offset
//  csr_     in   csr_we                csr_wdata heap_request
//
// Free does one header read and one write. Allocate and coalesce read one block
// header at a time (the header memory has registered read data, so one state
// issues the address and the next evaluates), so the time grows with the blocks.
// Reset is synchronous and clears the sequencer, sentinel and heap state; the
// header memory is not cleared. req_tready is low while an item is in work; the
// next item may be taken while a result waits in the output register.
`default_nettype none

module first_fit_block_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // [1:0] command
   input  wire logic [23:0] req_tdata,   // [11:0] request_bytes, [23:12] block_offset
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [0:0]       rsp_tuser,   // [0] ok
   output logic [15:0]      rsp_tdata,   // [11:0] result_offset, [15:12] zero
   input  wire logic        csr_we,
   input  wire logic [11:0] csr_wdata    // [11:0] heap_request
);

   logic [ffba_pkg::OFF_W-1:0] heap_req_ff, heap_req_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   ffba_pkg::result_type       rsp_data_ff, rsp_data_in;

   ffba_pkg::job_type          job;
   ffba_pkg::result_type       result;
   logic                       done_valid;
   logic                       done_ready;

   assign job = '{cmd:           ffba_pkg::cmd_type'(req_tuser),
                  request_bytes: req_tdata[11:0],
                  block_offset:  req_tdata[23:12],
                  heap_request:  heap_req_ff};

   assign done_ready = !rsp_valid_ff || rsp_tready;

   ffba_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (req_tvalid),
      .job        (job),
      .job_ready  (req_tready),
      .done_valid (done_valid),
      .result     (result),
      .done_ready (done_ready)
   );

   always_comb begin
      heap_req_in  = csr_we ? csr_wdata : heap_req_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_req_ff  <= ffba_pkg::HEAP_REQ_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         heap_req_ff  <= heap_req_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_data_ff.ok;
   assign rsp_tdata    = {4'b0, rsp_data_ff.result_offset};

endmodule

`default_nettype wire
